FILE: hdl/bca_pkg.sv
// Shared constants, codes and types of the block chain allocator.
package bca_pkg;

  // Table geometry and field widths
  localparam int TABLE_ENTRIES = 64;
  localparam int BLOCK_BYTES   = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 2);
  localparam int SIZE_W        = 24;
  localparam int WORD_W        = 16;
  localparam int WALK_LIMIT    = TABLE_ENTRIES + 1;

  localparam logic [WORD_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [WORD_W-1:0] FREE_MARK = 16'h0000;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FOLLOW  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ZERO     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_LINK_END,
    S_WALK_RD,
    S_WALK_EV,
    S_FOLLOW_RD,
    S_FOLLOW_EV,
    S_DONE
  } state_e;

  // Sequencer to table port controls
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic              clear;
  } tbl_ctrl_t;

endpackage

FILE: hdl/bca_if.sv
// Request and response channel interfaces of the block chain allocator.
interface bca_req_if;
  logic                          valid;
  logic                          ready;
  bca_pkg::kind_e                kind;
  logic [bca_pkg::SIZE_W-1:0]    byte_size;
  logic [5:0]                    start_block;

  modport source (output valid, kind, byte_size, start_block, input ready);
  modport sink   (input valid, kind, byte_size, start_block, output ready);
endinterface

interface bca_rsp_if;
  logic                          valid;
  logic                          ready;
  bca_pkg::status_e              status;
  logic [5:0]                    head_block;
  logic [bca_pkg::WORD_W-1:0]    link_word;
  logic [6:0]                    free_blocks;

  modport source (output valid, status, head_block, link_word, free_blocks, input ready);
  modport sink   (input valid, status, head_block, link_word, free_blocks, output ready);
endinterface

FILE: hdl/bca_table.sv
// Link table memory with per-entry valid bits; invalid entries read as free.
module bca_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bca_pkg::tbl_ctrl_t         ctrl_i,
  output logic [bca_pkg::WORD_W-1:0] rd_data_o
);
  import bca_pkg::*;

  logic [WORD_W-1:0]        mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [WORD_W-1:0]        rd_q;
  logic                     rd_valid_q;

  // Storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[ctrl_i.waddr] <= ctrl_i.wdata;
    end
    rd_q <= mem[ctrl_i.raddr];
  end

  // Valid bits: cleared at once by reset or a clear request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[ctrl_i.raddr];
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (ctrl_i.we) begin
        valid_q[ctrl_i.waddr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : FREE_MARK;

endmodule

FILE: hdl/block_chain_allocator.sv
// Top level of the block chain allocator: request sequencer and result register.
//
//   channel | dir | modport       | words
//   req_i   | in  | sink          | kind, byte_size, start_block
//   rsp_o   | out | source        | status, head_block, link_word, free_blocks
//
// Allocate reads then evaluates each entry scanned, then writes the end mark;
//   release does so for each link walked, follow for one entry; clear and
//   rejected requests go straight to done; the table read output is registered.
// Reset clears the table valid bits at once; no clearing pass is needed.
// A request is taken only in idle; a finished word waits in the result
// register, so the next request may be taken while the response is stalled.
module block_chain_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  bca_req_if.sink   req_i,
  bca_rsp_if.source rsp_o
);
  import bca_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  need_q, need_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  taken_q, taken_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic              have_prev_q, have_prev_d;
  status_e           st_q, st_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic              out_valid_q, out_valid_d;
  status_e           res_st_q, res_st_d;
  logic [IDX_W-1:0]  res_head_q, res_head_d;
  logic [WORD_W-1:0] res_word_q, res_word_d;
  logic [CNT_W-1:0]  res_free_q, res_free_d;

  tbl_ctrl_t         tbl_ctrl;
  logic [WORD_W-1:0] rd_data;

  logic [SIZE_W-1:0] quot_c, rem_c;
  logic [SIZE_W:0]   blk_c;
  logic [CNT_W-1:0]  need_c;
  logic              accept;
  logic              start_oob;
  logic              rd_free;
  logic              walk_stop;
  logic              scan_done;
  logic              load_res;

  bca_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tbl_ctrl),
    .rd_data_o (rd_data)
  );

  // Round the byte size up to whole blocks, saturated at the walk limit
  assign quot_c = req_i.byte_size / SIZE_W'(BLOCK_BYTES);
  assign rem_c  = req_i.byte_size % SIZE_W'(BLOCK_BYTES);
  assign blk_c  = (SIZE_W+1)'(quot_c) + (SIZE_W+1)'(rem_c != '0);
  assign need_c = (blk_c > (SIZE_W+1)'(WALK_LIMIT)) ? CNT_W'(WALK_LIMIT)
                                                     : blk_c[CNT_W-1:0];

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign start_oob   = ({1'b0, req_i.start_block} >= (IDX_W+1)'(TABLE_ENTRIES));
  assign rd_free     = (rd_data == FREE_MARK);
  assign walk_stop   = ((idx_q + 1'b1) == need_q) || (rd_data == END_MARK) ||
                       (rd_data >= WORD_W'(TABLE_ENTRIES));
  assign scan_done   = (rd_free && ((taken_q + 1'b1) == need_q)) ||
                       (idx_q == CNT_W'(TABLE_ENTRIES - 1));
  assign load_res    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.kind)
            KIND_ALLOC: begin
              if (need_c == '0 || need_c > free_q) state_d = S_DONE;
              else                                 state_d = S_SCAN_RD;
            end
            KIND_RELEASE: begin
              if (need_c == '0 || start_oob) state_d = S_DONE;
              else                           state_d = S_WALK_RD;
            end
            KIND_FOLLOW: begin
              if (start_oob) state_d = S_DONE;
              else           state_d = S_FOLLOW_RD;
            end
            KIND_CLEAR: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_RD:   state_d = S_SCAN_EV;
      S_SCAN_EV:   state_d = scan_done ? S_LINK_END : S_SCAN_RD;
      S_LINK_END:  state_d = S_DONE;
      S_WALK_RD:   state_d = S_WALK_EV;
      S_WALK_EV:   state_d = walk_stop ? S_DONE : S_WALK_RD;
      S_FOLLOW_RD: state_d = S_FOLLOW_EV;
      S_FOLLOW_EV: state_d = S_DONE;
      S_DONE:      state_d = load_res ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath and table controls
  always_comb begin
    need_d      = need_q;
    idx_d       = idx_q;
    taken_d     = taken_q;
    free_d      = free_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    st_d        = st_q;
    head_d      = head_q;
    word_d      = word_q;
    tbl_ctrl    = '{we: 1'b0, waddr: cur_q, wdata: FREE_MARK, raddr: cur_q,
                    clear: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          need_d      = need_c;
          idx_d       = '0;
          taken_d     = '0;
          have_prev_d = 1'b0;
          cur_d       = req_i.start_block;
          st_d        = ST_OK;
          head_d      = '0;
          word_d      = FREE_MARK;
          unique case (req_i.kind)
            KIND_ALLOC: begin
              if (need_c == '0)        st_d = ST_ZERO;
              else if (need_c > free_q) st_d = ST_NO_SPACE;
            end
            KIND_CLEAR: begin
              tbl_ctrl.clear = 1'b1;
              free_d         = CNT_W'(TABLE_ENTRIES);
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        tbl_ctrl.raddr = idx_q[IDX_W-1:0];
      end
      S_SCAN_EV: begin
        // Link the previous free block to this one; its end marker comes last
        if (rd_free) begin
          if (have_prev_q) begin
            tbl_ctrl.we    = 1'b1;
            tbl_ctrl.waddr = prev_q;
            tbl_ctrl.wdata = WORD_W'(idx_q);
          end else begin
            head_d = idx_q[IDX_W-1:0];
          end
          prev_d      = idx_q[IDX_W-1:0];
          have_prev_d = 1'b1;
          taken_d     = taken_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      S_LINK_END: begin
        tbl_ctrl.we    = 1'b1;
        tbl_ctrl.waddr = prev_q;
        tbl_ctrl.wdata = END_MARK;
        free_d         = free_q - taken_q;
      end
      S_WALK_RD: begin
        tbl_ctrl.raddr = cur_q;
      end
      S_WALK_EV: begin
        // Free a used entry, then follow its link
        if (!rd_free) begin
          tbl_ctrl.we    = 1'b1;
          tbl_ctrl.waddr = cur_q;
          tbl_ctrl.wdata = FREE_MARK;
          free_d         = free_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        cur_d = rd_data[IDX_W-1:0];
      end
      S_FOLLOW_RD: begin
        tbl_ctrl.raddr = cur_q;
      end
      S_FOLLOW_EV: begin
        word_d = rd_data;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    res_st_d    = res_st_q;
    res_head_d  = res_head_q;
    res_word_d  = res_word_q;
    res_free_d  = res_free_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_res) begin
      out_valid_d = 1'b1;
      res_st_d    = st_q;
      res_head_d  = head_q;
      res_word_d  = word_q;
      res_free_d  = free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= CNT_W'(TABLE_ENTRIES);
      out_valid_q <= 1'b0;
      have_prev_q <= 1'b0;
      need_q      <= '0;
      idx_q       <= '0;
      taken_q     <= '0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      have_prev_q <= have_prev_d;
      need_q      <= need_d;
      idx_q       <= idx_d;
      taken_q     <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    st_q       <= st_d;
    head_q     <= head_d;
    word_q     <= word_d;
    res_st_q   <= res_st_d;
    res_head_q <= res_head_d;
    res_word_q <= res_word_d;
    res_free_q <= res_free_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = res_st_q;
  assign rsp_o.head_block  = res_head_q;
  assign rsp_o.link_word   = res_word_q;
  assign rsp_o.free_blocks = res_free_q;

  // Checks
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CNT_W'(TABLE_ENTRIES))
    else $error("free count above table size");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !tbl_ctrl.we)
    else $error("table write outside a request");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("response word raised outside completion");

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_RD || state_q == S_SCAN_EV) |-> taken_q < need_q)
    else $error("allocation scan took more blocks than asked");

endmodule
